FILE: rtl/gwd_pkg.sv
// gerstner wave displacement package: wave word fields, sine table function
// no dependencies
package gwd_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned OUT_W   = 20;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned PH_FRAC = 26;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned WAVE_REGS = 8;
  localparam int unsigned IDX_W   = 3;

  typedef struct packed {
    logic signed [9:0]  qy;
    logic signed [9:0]  qx;
    logic        [9:0]  amp;
    logic        [9:0]  freq;
    logic signed [11:0] fy;
    logic signed [11:0] fx;
  } wave_t;

  // quarter-wave entry i of a table with tb address bits, Q15
  function automatic logic [15:0] sin_entry(input int unsigned i, input int unsigned tb);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] r;
    a = (64'(i) * 64'd6746518852) >> tb;
    a2 = (a * a) >> 30;
    term = a;
    sum = $signed(a);
    for (int n = 1; n <= 6; n++) begin
      term = ((term * a2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    r = (sum + 64'sd16384) >>> 15;
    if (r > 32768) r = 32768;
    return r[15:0];
  endfunction

endpackage

FILE: rtl/gerstner_wave_displacement_top.sv
// gerstner wave displacement top: config registers, wave lanes, sum and output
// depends on gwd_pkg and gwd_wave
//
// Input beats carry base_x, base_y (Q12.4) and time_now (Q16.16); each gives
// one output beat with displaced out_x, out_y and summed height out_z (Q15.4).
// Eight 64-bit wave words are written through the cfg port (index 0..7, other
// indexes ignored), ready always high; write them only while idle.
// Pipeline: three lane stages, a sum stage and an output register stage; one
// vertex is taken every cycle while the output is not stalled; the depth is set
// by the phase multiply, table lookup, term multiply and the sum of all lanes.
// A stall on the output freezes the whole pipeline; in_stall follows
// out_stall while the output holds a beat, so nothing is lost or repeated.
// Reset clears all wave words and the valid bits of every stage.
module gerstner_wave_displacement_top #(
  parameter int unsigned NUM_WAVES = 8,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         in_base_x,
  input  logic [15:0]         in_base_y,
  input  logic [31:0]         in_time_now,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [19:0]  out_x,
  output logic signed [19:0]  out_y,
  output logic signed [19:0]  out_z,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  localparam int unsigned SW = gwd_pkg::SUM_W;

  logic [63:0] word_r [gwd_pkg::WAVE_REGS];
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gwd_pkg::WAVE_REGS; i++) word_r[i] <= '0;
    end else if (cfg_valid) begin
      word_r[cfg_index] <= cfg_data;
    end
  end

  // whole pipeline advances unless a held output beat is stalled
  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  logic [4:0] v_r;
  logic [15:0] bx_r [3];
  logic [15:0] by_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[3:0], in_valid};
  end
  always_ff @(posedge clk) begin
    if (en) begin
      bx_r[0] <= in_base_x; by_r[0] <= in_base_y;
      bx_r[1] <= bx_r[0];   by_r[1] <= by_r[0];
      bx_r[2] <= bx_r[1];   by_r[2] <= by_r[1];
    end
  end

  logic signed [SW-1:0] tx [NUM_WAVES];
  logic signed [SW-1:0] ty [NUM_WAVES];
  logic signed [SW-1:0] tz [NUM_WAVES];
  for (genvar g = 0; g < NUM_WAVES; g++) begin : g_wave
    gwd_wave #(.TB(SINE_TABLE_BITS)) u_wave (
      .clk(clk), .en(en), .wave(gwd_pkg::wave_t'(word_r[g])),
      .bx(in_base_x), .by(in_base_y), .t(in_time_now),
      .tx(tx[g]), .ty(ty[g]), .tz(tz[g])
    );
  end

  // sum stage
  logic signed [SW-1:0] sx_nxt, sy_nxt, sz_nxt, sx_r, sy_r, sz_r;
  always_comb begin
    sx_nxt = $signed({4'd0, bx_r[2], 15'd0}) + SW'(0);
    sy_nxt = $signed({4'd0, by_r[2], 15'd0}) + SW'(0);
    sz_nxt = '0;
    for (int i = 0; i < NUM_WAVES; i++) begin
      sx_nxt = sx_nxt - tx[i];
      sy_nxt = sy_nxt - ty[i];
      sz_nxt = sz_nxt + tz[i];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sx_r <= sx_nxt; sy_r <= sy_nxt; sz_r <= sz_nxt;
    end
  end

  function automatic logic signed [19:0] fin(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] r;
    r = (s + SW'(16384)) >>> 15;
    if (r > SW'(524287)) return 20'sd524287;
    if (r < -SW'(524288)) return -20'sd524288;
    return r[19:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      out_x <= fin(sx_r); out_y <= fin(sy_r); out_z <= fin(sz_r);
    end
  end
  assign out_valid = v_r[4];
endmodule

FILE: rtl/gwd_wave.sv
// one wave lane: phase, table lookup, weighted terms, three register stages
// depends on gwd_pkg
module gwd_wave #(
  parameter int unsigned TB = 10
) (
  input  logic                          clk,
  input  logic                          en,
  input  gwd_pkg::wave_t                wave,
  input  logic [gwd_pkg::COORD_W-1:0]   bx,
  input  logic [gwd_pkg::COORD_W-1:0]   by,
  input  logic [gwd_pkg::TIME_W-1:0]    t,
  output logic signed [gwd_pkg::SUM_W-1:0] tx,
  output logic signed [gwd_pkg::SUM_W-1:0] ty,
  output logic signed [gwd_pkg::SUM_W-1:0] tz
);
  localparam int unsigned QL = 1 << (TB - 2);
  localparam int unsigned PF = gwd_pkg::PH_FRAC;

  logic [15:0] rom [QL+1];
  always_comb begin
    for (int i = 0; i <= QL; i++) rom[i] = gwd_pkg::sin_entry(i, TB);
  end

  // stage 1: products
  logic [PF-1:0] px_r, py_r, pt_r;
  gwd_pkg::wave_t w1_r;
  logic signed [28:0] mx, my;
  logic [41:0] mt;
  assign mx = $signed(wave.fx) * $signed({1'b0, bx});
  assign my = $signed(wave.fy) * $signed({1'b0, by});
  assign mt = wave.freq * t;
  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= {mx[PF-9:0], 8'd0};
      py_r <= {my[PF-9:0], 8'd0};
      pt_r <= mt[PF-1:0];
      w1_r <= wave;
    end
  end

  // stage 2: phase and lookup
  logic [PF-1:0] ph;
  logic [TB-1:0] sa, ca;
  logic signed [16:0] s2_r, c2_r;
  gwd_pkg::wave_t w2_r;
  assign ph = px_r + py_r - pt_r;
  assign sa = ph[PF-1 -: TB];
  assign ca = sa + TB'(QL);

  function automatic logic signed [16:0] lut(input logic [TB-1:0] ad);
    logic [TB-3:0] off;
    logic [15:0] v;
    off = ad[TB-3:0];
    v = ad[TB-2] ? rom[(TB-1)'(QL) - {1'b0, off}] : rom[{1'b0, off}];
    return ad[TB-1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= lut(sa);
      c2_r <= lut(ca);
      w2_r <= w1_r;
    end
  end

  // stage 3: weighted terms, zero word adds nothing
  logic act;
  logic signed [27:0] pz, px3, py3;
  assign act = (w2_r != '0);
  assign pz = $signed({1'b0, w2_r.amp}) * s2_r;
  assign px3 = $signed(w2_r.qx) * c2_r;
  assign py3 = $signed(w2_r.qy) * c2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      tz <= act ? gwd_pkg::SUM_W'(pz) : '0;
      tx <= act ? gwd_pkg::SUM_W'(px3) : '0;
      ty <= act ? gwd_pkg::SUM_W'(py3) : '0;
    end
  end
endmodule
